@@ rtl/scle_pkg.sv @@
// ----------------------------------------------------------------------------
// scle_pkg
// Shared types, codes and key tables for the scan code line editor.
// ----------------------------------------------------------------------------
package scle_pkg;

   // request opcodes
   localparam logic [1:0] OP_SCAN    = 2'd0;
   localparam logic [1:0] OP_COLLECT = 2'd1;
   localparam logic [1:0] OP_ARM     = 2'd2;

   // result kinds
   localparam logic [2:0] K_NONE     = 3'd0;
   localparam logic [2:0] K_CHAR     = 3'd1;
   localparam logic [2:0] K_BS       = 3'd2;
   localparam logic [2:0] K_NL       = 3'd3;
   localparam logic [2:0] K_SWITCH   = 3'd4;
   localparam logic [2:0] K_BYTE     = 3'd5;
   localparam logic [2:0] K_NOTREADY = 3'd6;
   localparam logic [2:0] K_EMPTY    = 3'd7;

   // set 1 scan codes
   localparam logic [7:0] SC_CTRL_DN   = 8'h1D;
   localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
   localparam logic [7:0] SC_ALT_DN    = 8'h38;
   localparam logic [7:0] SC_ALT_UP    = 8'hB8;
   localparam logic [7:0] SC_LSHIFT_DN = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_DN = 8'h36;
   localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] SC_CAPS      = 8'h3A;
   localparam logic [7:0] SC_F1        = 8'h3B;
   localparam logic [7:0] SC_F3        = 8'h3D;
   localparam logic [7:0] SC_KEY_L     = 8'h26;
   localparam logic [7:0] SC_KEY_A     = 8'h1E;
   localparam logic [7:0] SC_KEY_C     = 8'h2E;
   localparam logic [7:0] SC_BKSP      = 8'h0E;
   localparam logic [7:0] SC_ENTER     = 8'h1C;
   localparam logic [7:0] SC_TAB       = 8'h0F;
   localparam logic [7:0] SC_UP        = 8'h48;
   localparam logic [7:0] SC_LEFT      = 8'h4B;
   localparam logic [7:0] SC_RIGHT     = 8'h4D;
   localparam logic [7:0] SC_DOWN      = 8'h50;

   // characters
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_CTRL_L = 8'h0C;
   localparam logic [7:0] CH_CTRL_A = 8'h01;
   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   localparam int LEN_W   = 7;
   localparam int MAP_LEN = 60;

   localparam logic [7:0] LOWER_MAP [MAP_LEN] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h11, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h10, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h10, 8'h00,
      8'h00, 8'h20, 8'h00, 8'h00};

   localparam logic [7:0] UPPER_MAP [MAP_LEN] = '{
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0D, 8'h11, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
      8'h22, 8'h7E, 8'h10, 8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F, 8'h10, 8'h00,
      8'h00, 8'h20, 8'h00, 8'h00};

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       scan;
      logic [LEN_W-1:0] max_bytes;
      logic [7:0]       lower_ch;
      logic [7:0]       upper_ch;
   } scle_item_type;

   function automatic logic [7:0] lower_char(input logic [6:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (idx < 7'(MAP_LEN)) r = LOWER_MAP[idx[5:0]];
      return r;
   endfunction

   function automatic logic [7:0] upper_char(input logic [6:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (idx < 7'(MAP_LEN)) r = UPPER_MAP[idx[5:0]];
      return r;
   endfunction

endpackage

@@ rtl/scan_code_line_editor.sv @@
// A scan byte passes the queue register, then the result register. The queue takes
// one request per cycle while it has room, the back end one scan byte per cycle
// while idle with the result register free; a full line adds a newline result, and
// a collect moves each byte through the store read register to the result register.
// Reset: synchronous, clears key state, line length and queue; store is not cleared.
// ----------------------------------------------------------------------------
// scan_code_line_editor
// Set 1 scan code decoder and line editor with a queued front and back end.
// ----------------------------------------------------------------------------
module scan_code_line_editor import scle_pkg::*; #(
   parameter int LINE_BYTES = 64,
   parameter int TABLE_KEYS = 89
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_scan_code,
   input  logic [LEN_W-1:0]    req_max_bytes,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_char_out,
   output logic [1:0]          rsp_terminal,
   output logic                rsp_line_done,
   output logic [LEN_W-1:0]    rsp_char_count,
   output logic                rsp_last
);

   logic          q_valid, q_pop;
   scle_item_type q_item;

   scle_front #(.TABLE_KEYS(TABLE_KEYS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_scan_code,
      .req_max_bytes, .q_valid, .q_item, .q_pop
   );

   scle_back #(.LINE_BYTES(LINE_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_pop, .rsp_valid, .rsp_ready,
      .rsp_kind, .rsp_char_out, .rsp_terminal, .rsp_line_done,
      .rsp_char_count, .rsp_last
   );

   // line length never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_count <= LEN_W'(LINE_BYTES))
      else $error("char count beyond line store");

   // only a switch result carries a terminal index
   a_term_only_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != K_SWITCH) |-> rsp_terminal == 2'd0)
      else $error("terminal index on non switch result");

   // line bytes report a cleared line
   a_byte_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == K_BYTE) |-> (rsp_char_count == '0 && !rsp_line_done))
      else $error("line byte with live line state");

endmodule

@@ rtl/scle_front.sv @@
// ----------------------------------------------------------------------------
// scle_front
// Accepts requests, looks up both key tables and queues them for the back end.
// ----------------------------------------------------------------------------
module scle_front import scle_pkg::*; #(
   parameter int TABLE_KEYS = 89
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_scan_code,
   input  logic [LEN_W-1:0]    req_max_bytes,
   output logic                q_valid,
   output scle_item_type       q_item,
   input  logic                q_pop
);

   scle_item_type ent_ff [2];
   scle_item_type ent_in [2];
   logic [1:0]    cnt_ff, cnt_in;
   scle_item_type new_item;
   logic          push, in_table;

   // classify the incoming request
   always_comb begin
      in_table          = {1'b0, req_scan_code} < 9'(TABLE_KEYS);
      new_item.op        = req_opcode;
      new_item.scan      = req_scan_code;
      new_item.max_bytes = req_max_bytes;
      new_item.lower_ch  = in_table ? lower_char(req_scan_code[6:0]) : 8'h00;
      new_item.upper_ch  = in_table ? upper_char(req_scan_code[6:0]) : 8'h00;
   end

   assign req_ready = cnt_ff != 2'd2;
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = ent_ff[0];

   // two entry queue, head in slot 0
   always_comb begin
      ent_in[0] = ent_ff[0];
      ent_in[1] = ent_ff[1];
      cnt_in    = cnt_ff;
      if (q_pop && q_valid) begin
         ent_in[0] = ent_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) ent_in[0] = new_item;
         else ent_in[1] = new_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

endmodule

@@ rtl/scle_back.sv @@
// ----------------------------------------------------------------------------
// scle_back
// Carries out queued requests: key state, line store and result register.
// ----------------------------------------------------------------------------
module scle_back import scle_pkg::*; #(
   parameter int LINE_BYTES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  scle_item_type       q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_char_out,
   output logic [1:0]          rsp_terminal,
   output logic                rsp_line_done,
   output logic [LEN_W-1:0]    rsp_char_count,
   output logic                rsp_last
);

   localparam int AW = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_BYTES);
   localparam logic [LEN_W-1:0] NEAR_FULL = LEN_W'(LINE_BYTES - 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic             lshift_ff, lshift_in, rshift_ff, rshift_in, caps_ff, caps_in;
   logic             ctrl_ff, ctrl_in, alt_ff, alt_in;
   logic [LEN_W-1:0] len_ff, len_in, idx_ff, idx_in, size_ff, size_in;
   logic             ready_ff, ready_in, armed_ff, armed_in;
   logic [7:0]       mem [LINE_BYTES];
   logic [7:0]       rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   logic [2:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic [1:0]       out_term_ff, out_term_in;
   logic             out_done_ff, out_done_in, out_last_ff, out_last_in;
   logic [LEN_W-1:0] out_count_ff, out_count_in;

   logic             out_free, load, emit, pend, take;
   logic             wr_en, shift, is_cursor;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_data, ch, s;
   logic [LEN_W-1:0] csize;

   assign out_free = !out_valid_ff || rsp_ready;
   assign take     = (state_ff == ST_IDLE) && q_valid && out_free;
   assign q_pop    = take;
   assign s        = q_item.scan;

   // main step logic
   always_comb begin
      state_in = state_ff;
      lshift_in = lshift_ff; rshift_in = rshift_ff; caps_in = caps_ff;
      ctrl_in = ctrl_ff; alt_in = alt_ff;
      len_in = len_ff; ready_in = ready_ff; armed_in = armed_ff;
      idx_in = idx_ff; size_in = size_ff;
      wr_en = 1'b0; wr_addr = len_ff[AW-1:0]; wr_data = 8'h00;
      emit = 1'b0; pend = 1'b0; load = 1'b0;
      out_kind_in = K_NONE; out_char_in = 8'h00; out_term_in = 2'd0;
      out_done_in = out_done_ff; out_count_in = out_count_ff; out_last_in = 1'b1;
      shift = lshift_ff || rshift_ff;
      ch = q_item.lower_ch;
      is_cursor = (s == SC_UP) || (s == SC_LEFT) || (s == SC_RIGHT) || (s == SC_DOWN);
      csize = (len_ff < q_item.max_bytes) ? len_ff : q_item.max_bytes;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               load = 1'b1;
               case (q_item.op)
                  OP_SCAN: begin
                     if (s == SC_CTRL_DN) ctrl_in = 1'b1;
                     else if (s == SC_CTRL_UP) ctrl_in = 1'b0;
                     else if (s == SC_ALT_DN) alt_in = 1'b1;
                     else if (s == SC_ALT_UP) alt_in = 1'b0;
                     else if (s == SC_LSHIFT_DN) lshift_in = 1'b1;
                     else if (s == SC_RSHIFT_DN) rshift_in = 1'b1;
                     else if (s == SC_LSHIFT_UP) lshift_in = 1'b0;
                     else if (s == SC_RSHIFT_UP) rshift_in = 1'b0;
                     else if (s == SC_CAPS) caps_in = !caps_ff;
                     else if (alt_ff && s >= SC_F1 && s <= SC_F3) begin
                        emit = 1'b1;
                        out_kind_in = K_SWITCH;
                        out_term_in = 2'(s - SC_F1);
                     end else if (armed_ff && ctrl_ff) begin
                        // control codes replace the line
                        if (s == SC_KEY_L || s == SC_KEY_A || s == SC_KEY_C) begin
                           wr_en = 1'b1;
                           wr_addr = '0;
                           wr_data = (s == SC_KEY_L) ? CH_CTRL_L :
                                     (s == SC_KEY_A) ? CH_CTRL_A : CH_CTRL_C;
                           len_in = LEN_W'(1);
                           ready_in = 1'b1;
                        end
                     end else if (s[7]) begin
                        ready_in = ready_ff;
                     end else if (s == SC_BKSP) begin
                        if (len_ff != '0 && armed_ff) begin
                           len_in = len_ff - LEN_W'(1);
                           emit = 1'b1;
                           out_kind_in = K_BS;
                           out_char_in = CH_BS;
                        end
                     end else if (s == SC_ENTER) begin
                        if (armed_ff && len_ff < FULL_LEN) begin
                           wr_en = 1'b1;
                           wr_data = CH_NL;
                           len_in = len_ff + LEN_W'(1);
                        end
                        ready_in = 1'b1;
                        emit = 1'b1;
                        out_kind_in = K_NL;
                        out_char_in = CH_NL;
                     end else begin
                        // shift and caps rules
                        if ((caps_ff != shift) && ch >= CH_LOW_A && ch <= CH_LOW_Z)
                           ch = ch - CASE_GAP;
                        if (shift && !(ch >= CH_UP_A && ch <= CH_UP_Z)
                            && !(ch >= CH_LOW_A && ch <= CH_LOW_Z))
                           ch = q_item.upper_ch;
                        if (s == SC_TAB) ch = CH_SPACE;
                        if (s == SC_TAB || (ch != 8'h00 && !is_cursor)) begin
                           if (armed_ff && len_ff < FULL_LEN) begin
                              wr_en = 1'b1;
                              wr_data = ch;
                              len_in = len_ff + LEN_W'(1);
                           end
                           emit = 1'b1;
                           out_kind_in = K_CHAR;
                           out_char_in = ch;
                        end
                        if (len_in == NEAR_FULL) pend = 1'b1;
                     end
                  end
                  OP_COLLECT: begin
                     if (!(armed_ff && ready_ff)) begin
                        emit = 1'b1;
                        out_kind_in = K_NOTREADY;
                     end else if (csize == '0) begin
                        emit = 1'b1;
                        out_kind_in = K_EMPTY;
                        len_in = '0; ready_in = 1'b0; armed_in = 1'b0;
                     end else begin
                        load = 1'b0;
                        idx_in = '0;
                        size_in = csize;
                        state_in = ST_READ;
                     end
                  end
                  OP_ARM: begin
                     armed_in = 1'b1;
                     ready_in = 1'b0;
                  end
                  default: begin
                     armed_in = armed_ff;
                  end
               endcase
               // full line newline follows in its own cycle
               if (pend) begin
                  state_in = ST_FULL;
                  load = emit;
                  out_done_in = 1'b1;
                  out_count_in = len_in + LEN_W'(1);
                  out_last_in = 1'b0;
               end else begin
                  out_done_in = ready_in;
                  out_count_in = len_in;
               end
            end
         end
         ST_FULL: begin
            if (out_free) begin
               load = 1'b1;
               wr_en = 1'b1;
               wr_data = CH_NL;
               len_in = len_ff + LEN_W'(1);
               ready_in = 1'b1;
               out_kind_in = K_NL;
               out_char_in = CH_NL;
               out_done_in = 1'b1;
               out_count_in = len_in;
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (out_free) begin
               load = 1'b1;
               out_kind_in = K_BYTE;
               out_char_in = rd_data_ff;
               out_done_in = 1'b0;
               out_count_in = '0;
               out_last_in = idx_ff == size_ff - LEN_W'(1);
               idx_in = idx_ff + LEN_W'(1);
               if (out_last_in) begin
                  len_in = '0; ready_in = 1'b0; armed_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff  <= out_kind_in;
         out_char_ff  <= out_char_in;
         out_term_ff  <= out_term_in;
         out_done_ff  <= out_done_in;
         out_count_ff <= out_count_in;
         out_last_ff  <= out_last_in;
      end
      idx_ff  <= idx_in;
      size_ff <= size_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lshift_ff <= 1'b0; rshift_ff <= 1'b0; caps_ff <= 1'b0;
         ctrl_ff <= 1'b0; alt_ff <= 1'b0;
         len_ff <= '0; ready_ff <= 1'b0; armed_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lshift_ff <= lshift_in; rshift_ff <= rshift_in; caps_ff <= caps_in;
         ctrl_ff <= ctrl_in; alt_ff <= alt_in;
         len_ff <= len_in; ready_ff <= ready_in; armed_ff <= armed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_char_out   = out_char_ff;
   assign rsp_terminal   = out_term_ff;
   assign rsp_line_done  = out_done_ff;
   assign rsp_char_count = out_count_ff;
   assign rsp_last       = out_last_ff;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan code line editor testbench
// Drives scan bytes, arm and collect requests through the valid/ready request
// channel and checks every result against a line-editor predictor kept in a
// small scoreboard class, with random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb import scle_pkg::*; ();

   localparam int LINE_MAX  = 64;
   localparam int KEY_LIMIT = 89;
   localparam int QUIET_MAX = 3000;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [1:0] term;
      logic       done;
      logic [6:0] count;
      logic       last;
   } editor_result_type;

   // scoreboard: editor state and the queue of expected results
   class line_editor_board;
      bit lshift, rshift, caps, ctrl, alt;
      logic [7:0] store [LINE_MAX];
      int unsigned len;
      bit ready, armed;
      editor_result_type due_q[$];
      editor_result_type step_q[$];
      int errors, requests, results;
      int kind_seen [8];

      task report(string what, logic [7:0] got, logic [7:0] want);
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
         errors++;
      endtask

      function void emit(logic [2:0] k, logic [7:0] c, logic [1:0] t);
         editor_result_type r;
         if (step_q.size() >= 64) return;
         r.kind = k; r.ch = c; r.term = t; r.done = 0; r.count = 0; r.last = 0;
         step_q.push_back(r);
      endfunction

      function void put(logic [7:0] c);
         if (len < LINE_MAX) begin
            store[len] = c;
            len++;
         end
      endfunction

      function void set_line(logic [7:0] c);
         store[0] = c;
         len = 1;
         ready = 1;
      endfunction

      function logic [7:0] key_char(logic [7:0] s, bit shifted);
         logic [7:0] c;
         c = 8'h00;
         if (s < KEY_LIMIT && s < MAP_LEN) c = shifted ? UPPER_MAP[s] : LOWER_MAP[s];
         return c;
      endfunction

      function void scan(logic [7:0] s);
         bit sh;
         logic [7:0] c;
         case (s)
            SC_CTRL_DN:   begin ctrl = 1; return; end
            SC_CTRL_UP:   begin ctrl = 0; return; end
            SC_ALT_DN:    begin alt = 1; return; end
            SC_ALT_UP:    begin alt = 0; return; end
            SC_LSHIFT_DN: begin lshift = 1; return; end
            SC_RSHIFT_DN: begin rshift = 1; return; end
            SC_LSHIFT_UP: begin lshift = 0; return; end
            SC_RSHIFT_UP: begin rshift = 0; return; end
            SC_CAPS:      begin caps = !caps; return; end
            default: ;
         endcase
         if (alt && s >= SC_F1 && s <= SC_F3) begin
            emit(K_SWITCH, 8'h00, 2'(s - SC_F1));
            return;
         end
         // with ctrl held while armed, control codes swallow every other byte
         if (armed && ctrl) begin
            if (s == SC_KEY_L) set_line(CH_CTRL_L);
            else if (s == SC_KEY_A) set_line(CH_CTRL_A);
            else if (s == SC_KEY_C) set_line(CH_CTRL_C);
            return;
         end
         if (s[7]) return;
         if (s == SC_BKSP) begin
            if (len != 0 && armed) begin
               len--;
               emit(K_BS, CH_BS, 0);
            end
            return;
         end
         if (s == SC_ENTER) begin
            if (armed) put(CH_NL);
            ready = 1;
            emit(K_NL, CH_NL, 0);
            return;
         end
         sh = lshift || rshift;
         c = key_char(s, 0);
         if ((caps != sh) && c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_GAP;
         if (sh && !(c >= CH_UP_A && c <= CH_UP_Z) && !(c >= CH_LOW_A && c <= CH_LOW_Z))
            c = key_char(s, 1);
         if (s == SC_TAB) begin
            if (armed) put(CH_SPACE);
            emit(K_CHAR, CH_SPACE, 0);
         end else if (c != 0 && s != SC_UP && s != SC_LEFT && s != SC_RIGHT
                      && s != SC_DOWN) begin
            if (armed) put(c);
            emit(K_CHAR, c, 0);
         end
         // automatic newline once the line is nearly full
         if (len == LINE_MAX - 2) begin
            put(CH_NL);
            ready = 1;
            emit(K_NL, CH_NL, 0);
         end
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] s, logic [6:0] mb);
         int unsigned n;
         requests++;
         step_q.delete();
         if (op == OP_SCAN) scan(s);
         else if (op == OP_COLLECT) begin
            if (!(armed && ready)) emit(K_NOTREADY, 0, 0);
            else begin
               n = (len < mb) ? len : mb;
               if (n == 0) emit(K_EMPTY, 0, 0);
               for (int i = 0; i < n; i++) emit(K_BYTE, store[i], 0);
               len = 0; ready = 0; armed = 0;
            end
         end else if (op == OP_ARM) begin
            armed = 1;
            ready = 0;
         end
         if (step_q.size() == 0) emit(K_NONE, 0, 0);
         foreach (step_q[i]) begin
            step_q[i].done  = ready;
            step_q[i].count = 7'(len);
            step_q[i].last  = (i == step_q.size() - 1);
            due_q.push_back(step_q[i]);
         end
      endfunction

      task check_result(editor_result_type got);
         editor_result_type w;
         results++;
         if (due_q.size() == 0) begin
            report("unexpected result kind", 8'(got.kind), 8'h00);
            return;
         end
         w = due_q.pop_front();
         kind_seen[w.kind]++;
         if (got.kind !== w.kind) report("kind", 8'(got.kind), 8'(w.kind));
         if (got.ch !== w.ch) report("char_out", got.ch, w.ch);
         if (got.term !== w.term) report("terminal", 8'(got.term), 8'(w.term));
         if (got.done !== w.done) report("line_done", 8'(got.done), 8'(w.done));
         if (got.count !== w.count) report("char_count", 8'(got.count), 8'(w.count));
         if (got.last !== w.last) report("last", 8'(got.last), 8'(w.last));
      endtask
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_SCAN;
   logic [7:0] req_scan_code = 8'h00;
   logic [6:0] req_max_bytes = 7'd0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic [1:0] rsp_terminal;
   logic       rsp_line_done;
   logic [6:0] rsp_char_count;
   logic       rsp_last;

   line_editor_board board;
   int  idle_pct = 22;
   bit  hold_now = 0;
   int  quiet = 0;

   scan_code_line_editor dut (.*);

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      editor_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.kind = rsp_kind; r.ch = rsp_char_out; r.term = rsp_terminal;
         r.done = rsp_line_done; r.count = rsp_char_count; r.last = rsp_last;
         board.check_result(r);
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 0;
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
         $display("watchdog expired with %0d results outstanding", board.due_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task send_req(logic [1:0] op, logic [7:0] s, logic [6:0] mb);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid     <= 1;
      req_opcode    <= op;
      req_scan_code <= s;
      req_max_bytes <= mb;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, s, mb);
   endtask

   task key(logic [7:0] s);
      send_req(OP_SCAN, s, 7'($urandom_range(127)));
   endtask

   // mostly printable keys, with modifiers, editing keys and noise mixed in
   function logic [7:0] random_key();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 8'($urandom_range(2, 57));
      if (p < 66) return SC_BKSP;
      if (p < 70) return SC_TAB;
      if (p < 74) return $urandom_range(1) ? SC_LSHIFT_DN : SC_RSHIFT_DN;
      if (p < 80) return $urandom_range(1) ? SC_LSHIFT_UP : SC_RSHIFT_UP;
      if (p < 82) return SC_CAPS;
      if (p < 86) return 8'($urandom_range(58, 95));
      if (p < 92) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(255));
   endfunction

   task type_line(int n);
      logic [7:0] s;
      for (int i = 0; i < n; i++) begin
         s = random_key();
         // never leave ctrl or alt held across a line
         if (s == SC_CTRL_DN || s == SC_ALT_DN) s = SC_CAPS;
         key(s);
      end
   endtask

   task finish_line();
      int p;
      p = $urandom_range(99);
      if (p < 70) key(SC_ENTER);
      else if (p < 95) begin
         key(SC_CTRL_DN);
         case ($urandom_range(2))
            0: key(SC_KEY_L);
            1: key(SC_KEY_A);
            default: key(SC_KEY_C);
         endcase
         key(SC_CTRL_UP);
      end
   endtask

   task collect_line();
      logic [6:0] mb;
      case ($urandom_range(4))
         0: mb = 0;
         1: mb = 7'(LINE_MAX);
         default: mb = 7'($urandom_range(1, LINE_MAX));
      endcase
      send_req(OP_COLLECT, 8'($urandom_range(255)), mb);
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: idle keys, modifiers, switches, control codes, collects
      send_req(2'd3, 8'hFF, 7'h7F);
      send_req(OP_COLLECT, 8'h00, 7'd64);
      key(8'h00); key(8'hFF); key(SC_BKSP); key(SC_ENTER);
      send_req(OP_ARM, 8'h00, 7'd0);
      key(SC_KEY_A); key(SC_LSHIFT_DN); key(SC_KEY_A); key(8'h02); key(SC_LSHIFT_UP);
      key(SC_CAPS); key(8'h10); key(SC_RSHIFT_DN); key(8'h10); key(8'h02);
      key(SC_RSHIFT_UP); key(SC_CAPS);
      key(SC_TAB); key(SC_UP); key(SC_LEFT); key(SC_RIGHT); key(SC_DOWN);
      key(8'h58); key(8'h59); key(SC_BKSP);
      key(SC_ALT_DN); key(SC_F1); key(8'h3C); key(SC_F3); key(SC_ALT_UP);
      key(SC_CTRL_DN); key(8'h9E); key(SC_KEY_L); key(SC_CTRL_UP);
      send_req(OP_COLLECT, 8'h00, 7'd0);
      send_req(OP_ARM, 8'h00, 7'd0);
      key(SC_KEY_A); key(SC_ENTER);
      send_req(OP_COLLECT, 8'h00, 7'd64);

      // random lines; one long line with the receiver held off
      for (int sess = 0; board.requests < 250; sess++) begin
         if (sess == 3) idle_pct = 0;
         if (sess == 7) idle_pct = 22;
         if ($urandom_range(9) == 0) send_req(2'($urandom_range(3)),
                                             8'($urandom_range(255)),
                                             7'($urandom_range(LINE_MAX)));
         send_req(OP_ARM, 8'($urandom_range(255)), 7'($urandom_range(LINE_MAX)));
         if (sess == 5) begin
            hold_now = 1;
            for (int i = 0; i < 66; i++) key(8'($urandom_range(16, 25)));
         end else type_line($urandom_range(1, 14));
         finish_line();
         collect_line();
      end
      req_valid <= 0;

      while (board.due_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d echoes, %0d newlines,",
               board.requests, board.results, board.kind_seen[K_CHAR],
               board.kind_seen[K_NL]);
      $display("%0d line bytes, %0d switches, %0d backspaces, %0d not-ready collects",
               board.kind_seen[K_BYTE], board.kind_seen[K_SWITCH],
               board.kind_seen[K_BS], board.kind_seen[K_NOTREADY]);
      if (board.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
